[src/double_date_to_ticks_defines.svh]
// assertion macros for the date to ticks block
`ifndef DOUBLE_DATE_TO_TICKS_DEFINES_SVH
`define DOUBLE_DATE_TO_TICKS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DDT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define DDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/ddt_pkg.sv]
package ddt_pkg;

   localparam int TicksWidth  = 62;
   localparam int StatusWidth = 2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_SCALE   = 2'd2
   } status_type;

   // 1899-12-30 in ms from 0001-01-01, and 10000-01-01 in ms
   localparam logic signed [49:0] EpochShiftMs = 50'sd59926435200000;
   localparam logic signed [49:0] LimitMs      = 50'sd315537897600000;
   localparam logic [26:0]        MsPerDay     = 27'd86400000;
   // odd factor of a day in ms: 86400000 = 84375 * 2^10
   localparam logic [16:0]        MsPerDayOdd  = 17'd84375;
   localparam logic [13:0]        TicksPerMs   = 14'd10000;

   // date interval bounds as binary64 patterns
   localparam logic [63:0] DateHighBits = 64'h41469241_00000000; // 2958466.0
   localparam logic [63:0] DateLowMag   = 64'h41241036_00000000; // 657435.0

   // state between the decode stage and the mantissa multiply stage
   typedef struct packed {
      logic        invalid;
      logic        neg;
      logic        zero;
      logic [10:0] exp;
      logic [52:0] mant;
      logic [19:0] day;     // whole days of the magnitude
   } dec_type;

   // product of a 53-bit mantissa and 86400000, sign and exponent
   typedef struct packed {
      logic        invalid;
      logic        neg;
      logic        zero;
      logic [10:0] exp;
      logic [79:0] prod;
      logic [47:0] day_ms;  // whole days in ms
   } mul_type;

   // truncated millisecond magnitude after rounding
   typedef struct packed {
      logic        invalid;
      logic        neg;
      logic [47:0] mag;
      logic [47:0] day_ms;
   } rnd_type;

   typedef struct packed {
      logic               invalid;
      logic signed [49:0] millis;
   } ofs_type;

endpackage

[src/ddt_decode.sv]
module ddt_decode (
   input  logic             [63:0] date_bits,
   output ddt_pkg::dec_type        dec
);
   import ddt_pkg::*;

   logic        sign;
   logic [10:0] exp;
   logic [51:0] frac;
   logic [52:0] mant;
   logic        is_nan;
   logic        in_range;

   assign sign = date_bits[63];
   assign exp  = date_bits[62:52];
   assign frac = date_bits[51:0];
   assign mant = {(exp != 11'd0), frac};
   assign is_nan = (exp == 11'h7ff) && (frac != 52'd0);

   // magnitude ordering of binary64 patterns matches integer ordering
   always_comb begin
      if (!sign) in_range = date_bits[62:0] < DateHighBits[62:0];
      else       in_range = date_bits[62:0] < DateLowMag[62:0];
   end

   always_comb begin
      dec.invalid = is_nan || !in_range;
      dec.neg     = sign && (date_bits[62:0] != 63'd0);
      dec.zero    = (exp == 11'd0);
      dec.exp     = (exp == 11'd0) ? 11'd1 : exp;
      dec.mant    = mant;
      // integer part of the magnitude, only needed below 2^20
      if (exp >= 11'd1023 && exp <= 11'd1075) dec.day = 20'(mant >> (11'd1075 - exp));
      else                                    dec.day = 20'd0;
   end
endmodule

[src/ddt_round.sv]
module ddt_round (
   input  ddt_pkg::mul_type mul,
   output ddt_pkg::rnd_type rnd
);
   import ddt_pkg::*;

   // prod has msb at bit 79 or 78; value = prod * 2^(exp-1075)
   logic        top;
   logic [52:0] m;       // leading 53 product bits, before rounding
   logic [53:0] m_rnd;
   logic        g, st;
   logic signed [12:0] e2;  // value = m * 2^e2
   logic [54:0] q;       // fixed point with 1 fractional bit
   logic [47:0] mag;
   logic [12:0] sh;
   logic [55:0] sfix;
   logic        lsb;

   always_comb begin
      top = mul.prod[79];
      if (top) begin
         m  = mul.prod[79:27];
         g  = mul.prod[26];
         st = |mul.prod[25:0];
         e2 = $signed({2'b00, mul.exp}) - 13'sd1075 + 13'sd27;
      end else begin
         m  = mul.prod[78:26];
         g  = mul.prod[25];
         st = |mul.prod[24:0];
         e2 = $signed({2'b00, mul.exp}) - 13'sd1075 + 13'sd26;
      end
      m_rnd = {1'b0, m} + {53'd0, (g && (st || m[0]))};
      if (m_rnd[53]) begin
         m_rnd = m_rnd >> 1;
         e2 = e2 + 13'sd1;
      end
      // scaled value is at most about 2.6e14, so e2 <= -5 here in range
      // add 0.5 in binary64: result keeps 53 bits, round to nearest even
      // work in units of 2^-1 when e2 >= -1, else exact fraction below half
      mag  = 48'd0;
      sh   = 13'd0;
      sfix = 56'd0;
      lsb  = 1'b0;
      q    = 55'd0;
      if (mul.zero && (mul.prod == 80'd0)) begin
         mag = 48'd0;
      end else if (e2 >= 13'sd0) begin
         mag = 48'(m_rnd[52:0] << e2[5:0]);
      end else if (e2 == -13'sd1) begin
         // value = m/2, adding half: (m+1)/2 exact in 53 bits unless carry
         q = {1'b0, m_rnd} + 55'd1;
         if (q[54:53] != 2'b00 && q[0]) begin
            // 54-bit result: drop lsb, round even
            mag = 48'(q >> 1);
            if (q[1]) mag = mag + 48'd1;
         end else begin
            mag = 48'(q >> 1);
         end
      end else begin
         // value < 2^52, ulp <= 2^-2; value + 0.5 exact when it fits 53 bits
         sh = 13'(-e2);
         if (sh > 13'd60) begin
            mag = 48'd0;
         end else begin
            sfix = 56'({2'b00, m_rnd} << 1) + (56'd1 << sh[5:0]);
            // sum in units 2^(e2-1), bit 0 always clear; a 54-bit sum drops
            // bit 1, which is an exact tie, so round to even on bit 2
            if (sfix[54] && sfix[1]) begin
               lsb  = sfix[2];
               sfix = sfix + (lsb ? 56'd2 : 56'd0);
               sfix = {sfix[55:2], 2'b00};
            end
            mag = 48'(sfix >> (sh[5:0] + 6'd1));
         end
      end
      rnd.invalid = mul.invalid;
      rnd.neg     = mul.neg;
      rnd.mag     = mag;
      rnd.day_ms  = mul.day_ms;
   end
endmodule

[src/double_date_to_ticks.sv]
// date to ticks converter
// req channel: one binary64 date per word, days since 1899-12-30
// rsp channel: 62-bit tick count plus a 2-bit status per word
// status 0 ok, 1 invalid date or nan, 2 out of tick scale; ticks 0 on error
// five register stages: decode, mantissa multiply, double rounding,
// negative fold and epoch offset, scale by 10000 and range check
// rsp_tvalid rises once an accepted word reaches the fifth stage register
// throughput one word per clock while rsp_tready is high; each stage holds unless the next moves
// when rsp_tready is low the pipe fills and req_tready drops; nothing lost
// reset clears the valid bits only; data registers are left alone
// the rounding stage holds an increment, an add and a shifter
// the day remainder for the fold comes from whole days times a day in ms
module double_date_to_ticks (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] date_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [61:0] ticks, [63:62] status
);
   import ddt_pkg::*;

   logic [4:0] vld_ff;
   logic [4:0] adv;

   dec_type dec_c, s1_ff;
   mul_type s2_ff;
   rnd_type rnd_c, s3_ff;
   ofs_type s4_ff;
   logic [61:0] tick_ff;
   logic [1:0]  stat_ff;

   logic signed [49:0] m_in;
   logic signed [49:0] rem_raw;
   logic signed [27:0] rem;
   logic signed [49:0] millis_in;
   logic [63:0] prod_in;
   logic [69:0] mant_prod;
   logic [37:0] day_prod;

   // stage advance: a stage loads when it is empty or its word moves on
   always_comb begin
      adv[4] = !vld_ff[4] || rsp_tready;
      adv[3] = !vld_ff[3] || adv[4];
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end
   assign req_tready = adv[0];

   ddt_decode u_dec (.date_bits(req_tdata), .dec(dec_c));
   ddt_round  u_rnd (.mul(s2_ff), .rnd(rnd_c));

   // products by the odd part of a day, the 2^10 factor is a shift
   always_comb begin
      mant_prod = 70'(s1_ff.mant) * 70'(MsPerDayOdd);
      day_prod  = 38'(s1_ff.day) * 38'(MsPerDayOdd);
   end

   // fold a negative count: m - 2*(m rem day), m rem via truncation
   // magnitude minus whole days lands in [-1, day], one correction step
   always_comb begin
      m_in = s3_ff.neg ? -$signed({2'd0, s3_ff.mag}) : $signed({2'd0, s3_ff.mag});
      rem_raw = $signed({2'd0, s3_ff.mag}) - $signed({2'd0, s3_ff.day_ms});
      if (rem_raw < 50'sd0)
         rem_raw = rem_raw + $signed({23'd0, MsPerDay});
      else if (rem_raw >= $signed({23'd0, MsPerDay}))
         rem_raw = rem_raw - $signed({23'd0, MsPerDay});
      rem = rem_raw[27:0];
      if (s3_ff.neg) millis_in = m_in + $signed({rem, 1'b0}) + EpochShiftMs;
      else           millis_in = m_in + EpochShiftMs;
      prod_in = 64'(s4_ff.millis) * 64'(TicksPerMs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 5'd0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_tvalid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
         if (adv[4]) vld_ff[4] <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) s1_ff <= dec_c;
      if (adv[1]) begin
         s2_ff.invalid <= s1_ff.invalid;
         s2_ff.neg     <= s1_ff.neg;
         s2_ff.zero    <= s1_ff.zero;
         s2_ff.exp     <= s1_ff.exp;
         s2_ff.prod    <= {mant_prod, 10'd0};
         s2_ff.day_ms  <= {day_prod, 10'd0};
      end
      if (adv[2]) s3_ff <= rnd_c;
      if (adv[3]) begin
         s4_ff.invalid <= s3_ff.invalid;
         s4_ff.millis  <= millis_in;
      end
      if (adv[4]) begin
         if (s4_ff.invalid) begin
            stat_ff <= STATUS_INVALID;
            tick_ff <= '0;
         end else if (s4_ff.millis < 50'sd0 || s4_ff.millis >= LimitMs) begin
            stat_ff <= STATUS_SCALE;
            tick_ff <= '0;
         end else begin
            stat_ff <= STATUS_OK;
            tick_ff <= prod_in[61:0];
         end
      end
   end

   assign rsp_tvalid = vld_ff[4];
   assign rsp_tdata  = {stat_ff, tick_ff};
endmodule

[src/double_date_to_ticks_checker.sv]
`include "double_date_to_ticks_defines.svh"

module double_date_to_ticks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   import ddt_pkg::*;

   `DDT_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `DDT_ASSERT_IMPL(err_zero, clock, reset, rsp_tvalid && rsp_tdata[63:62] != STATUS_OK,
      rsp_tdata[61:0] == 62'd0)
   `DDT_ASSERT_IMPL(stat_legal, clock, reset, rsp_tvalid, rsp_tdata[63:62] == STATUS_OK ||
      rsp_tdata[63:62] == STATUS_INVALID || rsp_tdata[63:62] == STATUS_SCALE)
   `DDT_ASSERT_IMPL(ready_open, clock, reset, !rsp_tvalid, req_tready)
endmodule

bind double_date_to_ticks double_date_to_ticks_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
